### src/qte_pkg.sv
package qte_pkg;

    // Field and datapath widths
    localparam int IN_W     = 16;
    localparam int PROD_W   = 32;
    localparam int TERM_W   = 35;
    localparam int SABS_W   = 30;
    localparam int SQ_W     = 63;
    localparam int CW       = 45;
    localparam int MW       = 42;
    localparam int ZW       = 26;
    localparam int RW       = 18;
    localparam int YAW_W    = 16;
    localparam int PITCH_W  = 15;

    // Pipeline shape
    localparam int NORM_EXP     = 40;
    localparam int NORM_STAGES  = 3;
    localparam int CORDIC_STEPS = 21;
    localparam int SQ_STEPS     = 32;
    localparam int ATAN_LAT     = 1 + NORM_STAGES + 1 + CORDIC_STEPS + 1;
    localparam int LAT          = 4 + SQ_STEPS + ATAN_LAT + 1;

    // Fixed constants
    localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(64'sd1073741824);
    localparam logic signed [ZW-1:0]     DEG180      = ZW'(32'sd5898240);
    localparam logic signed [RW-1:0]     YAW_LIMIT   = RW'(32'sd23040);
    localparam logic signed [RW-1:0]     PITCH_LIMIT = RW'(32'sd11520);

    // Side data carried alongside the square root
    typedef struct packed {
        logic signed [TERM_W-1:0] sp;
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic                     clamp;
        logic                     pos;
    } side_t;

    typedef struct packed {
        logic clamp;
        logic pos;
    } pflag_t;

    // atan(2^-i) in units of 2^-15 degree
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(32'sd1474560);
            1:       v = ZW'(32'sd870484);
            2:       v = ZW'(32'sd459940);
            3:       v = ZW'(32'sd233473);
            4:       v = ZW'(32'sd117189);
            5:       v = ZW'(32'sd58652);
            6:       v = ZW'(32'sd29333);
            7:       v = ZW'(32'sd14667);
            8:       v = ZW'(32'sd7334);
            9:       v = ZW'(32'sd3667);
            10:      v = ZW'(32'sd1833);
            11:      v = ZW'(32'sd917);
            12:      v = ZW'(32'sd458);
            13:      v = ZW'(32'sd229);
            14:      v = ZW'(32'sd115);
            15:      v = ZW'(32'sd57);
            16:      v = ZW'(32'sd29);
            17:      v = ZW'(32'sd14);
            18:      v = ZW'(32'sd7);
            19:      v = ZW'(32'sd4);
            20:      v = ZW'(32'sd2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/qte_atan2.sv
module qte_atan2 (
    input  logic                              clk,
    input  logic signed [qte_pkg::TERM_W-1:0] y_in,
    input  logic signed [qte_pkg::TERM_W-1:0] x_in,
    output logic signed [qte_pkg::RW-1:0]     angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] nx_reg [0:NORM_STAGES];
    logic signed [CW-1:0] ny_reg [0:NORM_STAGES];
    logic [MW-1:0]        nm_reg [0:NORM_STAGES];

    logic signed [CW-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STEPS];

    logic signed [RW-1:0] angle_reg;

    logic signed [CW-1:0] xe, ye, ax, ay;

    // Extend operands and form the joint magnitude mask
    always_comb
    begin
        xe = CW'(x_in);
        ye = CW'(y_in);
        ax = (xe < 0) ? -xe : xe;
        ay = (ye < 0) ? -ye : ye;
    end

    always_ff @(posedge clk)
    begin
        nx_reg[0] <= xe;
        ny_reg[0] <= ye;
        nm_reg[0] <= MW'(ax | ay);
    end

    // Normalize: double until the larger magnitude reaches 2^40
    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
        localparam int S_HI = 32 >> (2 * j);
        localparam int S_LO = 16 >> (2 * j);
        logic signed [CW-1:0] tx, ty;
        logic [MW-1:0]        tm;

        always_comb
        begin
            tx = nx_reg[j];
            ty = ny_reg[j];
            tm = nm_reg[j];
            if ((tm >> (NORM_EXP - S_HI)) == '0)
            begin
                tx = tx <<< S_HI;
                ty = ty <<< S_HI;
                tm = tm << S_HI;
            end
            if ((tm >> (NORM_EXP - S_LO)) == '0)
            begin
                tx = tx <<< S_LO;
                ty = ty <<< S_LO;
                tm = tm << S_LO;
            end
            if ((j == NORM_STAGES - 1) && ((tm >> NORM_EXP) == '0))
            begin
                tx = tx <<< 1;
                ty = ty <<< 1;
                tm = tm << 1;
            end
        end

        always_ff @(posedge clk)
        begin
            nx_reg[j+1] <= tx;
            ny_reg[j+1] <= ty;
            nm_reg[j+1] <= tm;
        end
    end

    // Fold the left half plane into the right one
    always_ff @(posedge clk)
    begin
        if (nx_reg[NORM_STAGES] < 0)
        begin
            cz_reg[0] <= (ny_reg[NORM_STAGES] >= 0) ? DEG180 : -DEG180;
            cx_reg[0] <= -nx_reg[NORM_STAGES];
            cy_reg[0] <= -ny_reg[NORM_STAGES];
        end
        else
        begin
            cz_reg[0] <= '0;
            cx_reg[0] <= nx_reg[NORM_STAGES];
            cy_reg[0] <= ny_reg[NORM_STAGES];
        end
    end

    // Vectoring rotations, one per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] xs, ys, x_next, y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs     = cx_reg[i] >>> i;
            ys     = cy_reg[i] >>> i;
            x_next = cx_reg[i];
            y_next = cy_reg[i];
            z_next = cz_reg[i];
            if (cy_reg[i] > 0)
            begin
                x_next = cx_reg[i] + ys;
                y_next = cy_reg[i] - xs;
                z_next = cz_reg[i] + atan_entry(i);
            end
            else if (cy_reg[i] < 0)
            begin
                x_next = cx_reg[i] - ys;
                y_next = cy_reg[i] + xs;
                z_next = cz_reg[i] - atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i+1] <= x_next;
            cy_reg[i+1] <= y_next;
            cz_reg[i+1] <= z_next;
        end
    end

    // Round to 1/128 degree, ties away from zero
    logic signed [ZW-1:0] zf, az, rz;

    always_comb
    begin
        zf = cz_reg[CORDIC_STEPS];
        az = (zf < 0) ? -zf : zf;
        rz = (az + ZW'(128)) >>> 8;
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= (zf < 0) ? -RW'(rz) : RW'(rz);
    end

    assign angle = angle_reg;

    // Normalized magnitude reaches 2^40 unless the vector is zero
    a_norm_top: assert property (@(posedge clk)
        !$isunknown(nm_reg[NORM_STAGES]) |->
        ((nm_reg[NORM_STAGES] >> NORM_EXP) != '0 || nm_reg[NORM_STAGES] == '0))
        else $error("normalization fell short");

    // Folded x is never negative
    a_fold_nonneg: assert property (@(posedge clk)
        !$isunknown(cx_reg[0]) |-> cx_reg[0] >= 0)
        else $error("folded x is negative");

    // Rotations only grow x, so the final x stays non-negative
    a_x_nonneg: assert property (@(posedge clk)
        !$isunknown(cx_reg[CORDIC_STEPS]) |-> cx_reg[CORDIC_STEPS] >= 0)
        else $error("cordic x went negative");

endmodule

### src/quaternion_to_euler.sv
// Pipeline: each accepted start travels the full pipeline to the done strobe.
// Throughput: one transaction per cycle; busy never rises. The depth is set
// by the 32-stage square root for pitch and the 21-stage CORDIC units.
// Reset: rst_n clears the valid pipeline asynchronously; in-flight work drops.
// The receiver cannot stall: each result shows for exactly one cycle.
module quaternion_to_euler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [qte_pkg::IN_W-1:0]    q_w,
    input  logic signed [qte_pkg::IN_W-1:0]    q_x,
    input  logic signed [qte_pkg::IN_W-1:0]    q_y,
    input  logic signed [qte_pkg::IN_W-1:0]    q_z,
    output logic                               done,
    output logic signed [qte_pkg::YAW_W-1:0]   yaw_angle,
    output logic signed [qte_pkg::PITCH_W-1:0] pitch_angle,
    output logic signed [qte_pkg::YAW_W-1:0]   roll_angle,
    output logic                               pitch_clamped
);
    import qte_pkg::*;

    logic vld_reg [0:LAT-1];

    logic signed [PROD_W-1:0] wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [PROD_W-1:0] yy_reg, zz_reg, wx_reg, yz_reg, xx_reg;

    logic signed [TERM_W-1:0] sp_reg, sy_reg, cy_reg, sr_reg, cr_reg;
    side_t                    s3_reg;
    logic [2*SABS_W-1:0]      sq_reg;

    logic [SQ_W-1:0] sv_reg [0:SQ_STEPS];
    logic [SQ_W-1:0] rt_reg [0:SQ_STEPS];
    side_t           sd_reg [0:SQ_STEPS];
    pflag_t          ck_reg [0:ATAN_LAT-1];

    logic signed [YAW_W-1:0]   yaw_reg, roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic                      clamp_reg;

    assign busy = 1'b0;

    // Track valid transactions through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage 1: component products
    always_ff @(posedge clk)
    begin
        wy_reg <= q_w * q_y;
        zx_reg <= q_z * q_x;
        wz_reg <= q_w * q_z;
        xy_reg <= q_x * q_y;
        yy_reg <= q_y * q_y;
        zz_reg <= q_z * q_z;
        wx_reg <= q_w * q_x;
        yz_reg <= q_y * q_z;
        xx_reg <= q_x * q_x;
    end

    // Stage 2: sine and cosine terms in Q5.30
    always_ff @(posedge clk)
    begin
        sp_reg <= (TERM_W'(wy_reg) - TERM_W'(zx_reg)) <<< 1;
        sy_reg <= (TERM_W'(wz_reg) + TERM_W'(xy_reg)) <<< 1;
        cy_reg <= ONE_Q30 - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
        sr_reg <= (TERM_W'(wx_reg) + TERM_W'(yz_reg)) <<< 1;
        cr_reg <= ONE_Q30 - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
    end

    // Stage 3: detect pitch clamp, square the pitch term
    logic signed [TERM_W-1:0] spa;
    logic [SABS_W-1:0]        sabs;

    always_comb
    begin
        spa  = (sp_reg < 0) ? -sp_reg : sp_reg;
        sabs = spa[SABS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sq_reg       <= sabs * sabs;
        s3_reg.sp    <= sp_reg;
        s3_reg.sy    <= sy_reg;
        s3_reg.cy    <= cy_reg;
        s3_reg.sr    <= sr_reg;
        s3_reg.cr    <= cr_reg;
        s3_reg.clamp <= (spa[TERM_W-1:SABS_W] != '0);
        s3_reg.pos   <= (sp_reg > 0);
    end

    // Stage 4: radicand 1 - s^2 in Q3.60
    always_ff @(posedge clk)
    begin
        sv_reg[0] <= (SQ_W'(1) << 60) - SQ_W'(sq_reg);
        rt_reg[0] <= '0;
        sd_reg[0] <= s3_reg;
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * k);
        logic [SQ_W-1:0] trial;

        assign trial = rt_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            sd_reg[k+1] <= sd_reg[k];
            if (sv_reg[k] >= trial)
            begin
                sv_reg[k+1] <= sv_reg[k] - trial;
                rt_reg[k+1] <= (rt_reg[k] >> 1) + BIT;
            end
            else
            begin
                sv_reg[k+1] <= sv_reg[k];
                rt_reg[k+1] <= rt_reg[k] >> 1;
            end
        end
    end

    // Three angle units in lockstep
    logic signed [TERM_W-1:0] cp;
    logic signed [RW-1:0]     yaw_raw, pitch_raw, roll_raw;
    side_t                    sf;

    assign sf = sd_reg[SQ_STEPS];
    assign cp = $signed(rt_reg[SQ_STEPS][TERM_W-1:0]);

    qte_atan2 u_pitch (
        .clk   (clk),
        .y_in  (sf.sp),
        .x_in  (cp),
        .angle (pitch_raw)
    );

    qte_atan2 u_yaw (
        .clk   (clk),
        .y_in  (sf.sy),
        .x_in  (sf.cy),
        .angle (yaw_raw)
    );

    qte_atan2 u_roll (
        .clk   (clk),
        .y_in  (sf.sr),
        .x_in  (sf.cr),
        .angle (roll_raw)
    );

    // Carry pitch flags alongside the angle units
    always_ff @(posedge clk)
    begin
        ck_reg[0].clamp <= sf.clamp;
        ck_reg[0].pos   <= sf.pos;
        for (int k = 1; k < ATAN_LAT; k++)
        begin
            ck_reg[k] <= ck_reg[k-1];
        end
    end

    // Output stage: limit angles and apply the pitch clamp
    logic signed [RW-1:0] yaw_lim, roll_lim, pitch_lim;
    pflag_t               pf;

    always_comb
    begin
        pf = ck_reg[ATAN_LAT-1];
        yaw_lim = yaw_raw;
        if (yaw_raw > YAW_LIMIT)
        begin
            yaw_lim = YAW_LIMIT;
        end
        else if (yaw_raw < -YAW_LIMIT)
        begin
            yaw_lim = -YAW_LIMIT;
        end
        roll_lim = roll_raw;
        if (roll_raw > YAW_LIMIT)
        begin
            roll_lim = YAW_LIMIT;
        end
        else if (roll_raw < -YAW_LIMIT)
        begin
            roll_lim = -YAW_LIMIT;
        end
        pitch_lim = pitch_raw;
        if (pf.clamp)
        begin
            pitch_lim = pf.pos ? PITCH_LIMIT : -PITCH_LIMIT;
        end
        else if (pitch_raw > PITCH_LIMIT)
        begin
            pitch_lim = PITCH_LIMIT;
        end
        else if (pitch_raw < -PITCH_LIMIT)
        begin
            pitch_lim = -PITCH_LIMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        yaw_reg   <= yaw_lim[YAW_W-1:0];
        roll_reg  <= roll_lim[YAW_W-1:0];
        pitch_reg <= pitch_lim[PITCH_W-1:0];
        clamp_reg <= pf.clamp;
    end

    assign done          = vld_reg[LAT-1];
    assign yaw_angle     = yaw_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign pitch_clamped = clamp_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LAT) done)
        else $error("transaction did not complete on time");

    a_clamp_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pitch_clamped) |->
        (pitch_angle == PITCH_W'(PITCH_LIMIT) || pitch_angle == -PITCH_W'(PITCH_LIMIT)))
        else $error("clamped pitch not at ninety degrees");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (yaw_angle <= YAW_W'(YAW_LIMIT) && yaw_angle >= -YAW_W'(YAW_LIMIT)
                  && roll_angle <= YAW_W'(YAW_LIMIT) && roll_angle >= -YAW_W'(YAW_LIMIT)))
        else $error("angle out of range");

endmodule
